// ===== hdl/igt_pkg.sv =====
// Shared constants, types and element helpers for the integer GEMM tile unit.
package igt_pkg;

	localparam int TILE_ROWS      = 4;
	localparam int TILE_COLS      = 2;
	localparam int ELEMS_PER_ITEM = 8;
	localparam int NUM_ACC        = TILE_ROWS * TILE_COLS;

	localparam int WORD_W     = 64;
	localparam int ACC_W      = 32;
	localparam int CNT_W      = 4;
	localparam int POS_W      = 2;
	localparam int ACC_IDX_W  = $clog2(NUM_ACC);
	localparam int ELEM_W     = 8;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int SHIFT_W    = 4;
	localparam int PREC_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// A element formats
	localparam logic [PREC_W-1:0] PREC_INT8 = 2'd0;
	localparam logic [PREC_W-1:0] PREC_INT4 = 2'd1;
	localparam logic [PREC_W-1:0] PREC_INT2 = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_PRECISION   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_OUT = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_EMIT
	} igt_state_t;

	typedef struct packed {
		logic                 load;
		logic                 mac;
		logic                 emit;
		logic                 clr;
		logic [ACC_IDX_W-1:0] emit_idx;
	} igt_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             tend;
		logic             out_free;
	} igt_sts_t;

	// Bit width of one A element; the reserved code decodes as int8.
	function automatic logic [SHIFT_W-1:0] a_width(input logic [PREC_W-1:0] prec);
		logic [SHIFT_W-1:0] w;
		case (prec)
			PREC_INT4: w = 4'd4;
			PREC_INT2: w = 4'd2;
			default:   w = 4'd8;
		endcase
		return w;
	endfunction

	// Sign extend the lowest A element of a byte to int8.
	function automatic logic signed [ELEM_W-1:0] a_elem(input logic [ELEM_W-1:0] raw,
		input logic [PREC_W-1:0] prec);
		logic signed [ELEM_W-1:0] v;
		case (prec)
			PREC_INT4: v = signed'({{4{raw[3]}}, raw[3:0]});
			PREC_INT2: v = signed'({{6{raw[1]}}, raw[1:0]});
			default:   v = signed'(raw);
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/igt_in_if.sv =====
// Input channel carrying one k-slice of A rows and B columns.
interface igt_in_if;
	logic                         valid;
	logic                         ready;
	logic [igt_pkg::WORD_W-1:0]   a_row0;
	logic [igt_pkg::WORD_W-1:0]   a_row1;
	logic [igt_pkg::WORD_W-1:0]   a_row2;
	logic [igt_pkg::WORD_W-1:0]   a_row3;
	logic [igt_pkg::WORD_W-1:0]   b_col0;
	logic [igt_pkg::WORD_W-1:0]   b_col1;
	logic [igt_pkg::CNT_W-1:0]    elem_count;
	logic                         tile_end;

	modport source (output valid, a_row0, a_row1, a_row2, a_row3, b_col0, b_col1,
		elem_count, tile_end, input ready);
	modport sink (input valid, a_row0, a_row1, a_row2, a_row3, b_col0, b_col1,
		elem_count, tile_end, output ready);
endinterface

// ===== hdl/igt_out_if.sv =====
// Result channel carrying one tile element per transaction.
interface igt_out_if;
	logic                              valid;
	logic                              ready;
	logic [igt_pkg::POS_W-1:0]         out_row;
	logic [igt_pkg::POS_W-1:0]         out_col;
	logic signed [igt_pkg::ACC_W-1:0]  value;
	logic                              last_of_tile;

	modport source (output valid, out_row, out_col, value, last_of_tile, input ready);
	modport sink (input valid, out_row, out_col, value, last_of_tile, output ready);
endinterface

// ===== hdl/igt_cfg_if.sv =====
// Configuration write channel.
interface igt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [igt_pkg::CFG_IDX_W-1:0]     index;
	logic [igt_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/int_gemm_tile_4x2_mixed_precision_unit.sv =====
// Top level of the mixed-precision integer GEMM 4x2 tile unit.
//
// Accumulates a 4x2 int32 tile of C = A * B from k-slices. Each slice
// transaction carries one packed 64-bit word per A row and per B column plus
// an element count (values above 8 act as 8). B is signed int8; A is signed
// int8, int4 or int2 by the a_precision register (code 3 acts as int8), with
// element e in the lowest bits first. A slice is accepted first; then the
// eight MAC lanes (one per accumulator, one 8x8 multiply each) consume one k
// element per cycle up to the saturated element count. A slice with tile_end
// set then emits eight result transactions, one per cycle unless held by
// result.ready, through a single output register, in row-major order of the
// stored tile (2x4 when transpose_out is set), and the accumulators clear;
// the next slice is taken once the last result is in the output register.
// Sums wrap modulo 2^32. Configuration writes are always taken; write them
// only while no slice is in flight and no tile is being emitted.
module int_gemm_tile_4x2_mixed_precision_unit (
	input  logic       clk,
	input  logic       arst_n,
	igt_in_if.sink     slice,
	igt_out_if.source  result,
	igt_cfg_if.sink    cfg
);

	logic [igt_pkg::PREC_W-1:0] a_prec_q;
	logic                       transpose_q;

	igt_pkg::igt_cmd_t          cmd;
	igt_pkg::igt_sts_t          sts;

	logic [igt_pkg::WORD_W-1:0] a_rows [igt_pkg::TILE_ROWS];
	logic [igt_pkg::WORD_W-1:0] b_cols [igt_pkg::TILE_COLS];

	// Configuration registers: accept every write, drop unknown indexes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_prec_q    <= igt_pkg::PREC_INT8;
			transpose_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				igt_pkg::REG_A_PRECISION:   a_prec_q    <= cfg.data[igt_pkg::PREC_W-1:0];
				igt_pkg::REG_TRANSPOSE_OUT: transpose_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Gather the operand words of a slice into row and column arrays.
	assign a_rows[0] = slice.a_row0;
	assign a_rows[1] = slice.a_row1;
	assign a_rows[2] = slice.a_row2;
	assign a_rows[3] = slice.a_row3;
	assign b_cols[0] = slice.b_col0;
	assign b_cols[1] = slice.b_col1;

	// Controller: accepts slices, steps elements, sequences the tile emission.
	igt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.slice_valid (slice.valid),
		.slice_ready (slice.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Datapath: operand shifters, MAC lanes, accumulators, result register.
	igt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.a_prec     (a_prec_q),
		.transpose  (transpose_q),
		.a_rows     (a_rows),
		.b_cols     (b_cols),
		.elem_count (slice.elem_count),
		.tile_end   (slice.tile_end),
		.res        (result)
	);

	// A result is loaded only when the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result.valid || result.ready))
		else $error("result loaded over an untaken result");

	// Accumulation and emission never overlap.
	a_mac_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mac && cmd.emit))
		else $error("MAC and emit in the same cycle");

	// Accumulators clear only with the final result of a tile.
	a_clr_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (result.valid && result.last_of_tile))
		else $error("accumulator clear without final result");

	// No accumulation or emission while a new slice may be accepted.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		slice.ready |-> !(cmd.mac || cmd.emit))
		else $error("slice accepted while busy");

endmodule

// ===== hdl/igt_ctrl.sv =====
// Sequencer for slice loading, per-element accumulation and tile emission.
module igt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              slice_valid,
	output logic              slice_ready,
	input  igt_pkg::igt_sts_t sts,
	output igt_pkg::igt_cmd_t cmd
);

	igt_pkg::igt_state_t state_q;
	igt_pkg::igt_state_t state_nxt;

	logic [igt_pkg::CNT_W-1:0]     elem_q;
	logic [igt_pkg::ACC_IDX_W-1:0] emit_q;
	logic                          last_elem;
	logic                          last_emit;

	assign last_elem = (igt_pkg::CNT_W'(elem_q + 1'b1) >= sts.cnt);
	assign last_emit = (emit_q == igt_pkg::ACC_IDX_W'(igt_pkg::NUM_ACC - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			igt_pkg::ST_IDLE: begin
				if (slice_valid) begin
					state_nxt = igt_pkg::ST_MAC;
				end
			end
			igt_pkg::ST_MAC: begin
				if (last_elem) begin
					state_nxt = sts.tend ? igt_pkg::ST_EMIT : igt_pkg::ST_IDLE;
				end
			end
			igt_pkg::ST_EMIT: begin
				if (sts.out_free && last_emit) begin
					state_nxt = igt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = igt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		slice_ready  = (state_q == igt_pkg::ST_IDLE);
		cmd.load     = (state_q == igt_pkg::ST_IDLE) && slice_valid;
		cmd.mac      = (state_q == igt_pkg::ST_MAC) && (elem_q < sts.cnt);
		cmd.emit     = (state_q == igt_pkg::ST_EMIT) && sts.out_free;
		cmd.clr      = cmd.emit && last_emit;
		cmd.emit_idx = emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= igt_pkg::ST_IDLE;
			elem_q  <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				elem_q <= '0;
			end else if (cmd.mac) begin
				elem_q <= igt_pkg::CNT_W'(elem_q + 1'b1);
			end
			if (cmd.emit) begin
				emit_q <= cmd.clr ? '0 : igt_pkg::ACC_IDX_W'(emit_q + 1'b1);
			end
		end
	end

endmodule

// ===== hdl/igt_dp.sv =====
// Operand shifters, eight MAC lanes, accumulators and the result register.
module igt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  igt_pkg::igt_cmd_t             cmd,
	output igt_pkg::igt_sts_t             sts,
	input  logic [igt_pkg::PREC_W-1:0]    a_prec,
	input  logic                          transpose,
	input  logic [igt_pkg::WORD_W-1:0]    a_rows [igt_pkg::TILE_ROWS],
	input  logic [igt_pkg::WORD_W-1:0]    b_cols [igt_pkg::TILE_COLS],
	input  logic [igt_pkg::CNT_W-1:0]     elem_count,
	input  logic                          tile_end,
	igt_out_if.source                     res
);

	logic [igt_pkg::WORD_W-1:0]    a_sh_q [igt_pkg::TILE_ROWS];
	logic [igt_pkg::WORD_W-1:0]    b_sh_q [igt_pkg::TILE_COLS];
	logic [igt_pkg::CNT_W-1:0]     cnt_q;
	logic                          tend_q;
	logic [igt_pkg::ACC_W-1:0]     acc_q [igt_pkg::NUM_ACC];
	logic signed [igt_pkg::PROD_W-1:0] prod [igt_pkg::NUM_ACC];
	logic [igt_pkg::SHIFT_W-1:0]   a_shift;

	logic                          out_valid_q;
	logic [igt_pkg::POS_W-1:0]     out_row_q;
	logic [igt_pkg::POS_W-1:0]     out_col_q;
	logic [igt_pkg::ACC_W-1:0]     out_value_q;
	logic                          out_last_q;

	logic [igt_pkg::POS_W-1:0]     e_row;
	logic [igt_pkg::POS_W-1:0]     e_col;
	logic [igt_pkg::ACC_IDX_W-1:0] e_acc;

	assign a_shift = igt_pkg::a_width(a_prec);

	// one element pair per lane, taken from the low end of the shifters
	always_comb begin
		for (int r = 0; r < igt_pkg::TILE_ROWS; r++) begin
			for (int c = 0; c < igt_pkg::TILE_COLS; c++) begin
				prod[r * igt_pkg::TILE_COLS + c] =
					igt_pkg::a_elem(a_sh_q[r][igt_pkg::ELEM_W-1:0], a_prec)
					* signed'(b_sh_q[c][igt_pkg::ELEM_W-1:0]);
			end
		end
	end

	// operands: load on accept, advance one element per MAC cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int r = 0; r < igt_pkg::TILE_ROWS; r++) begin
				a_sh_q[r] <= a_rows[r];
			end
			for (int c = 0; c < igt_pkg::TILE_COLS; c++) begin
				b_sh_q[c] <= b_cols[c];
			end
			cnt_q  <= (elem_count > igt_pkg::CNT_W'(igt_pkg::ELEMS_PER_ITEM))
				? igt_pkg::CNT_W'(igt_pkg::ELEMS_PER_ITEM) : elem_count;
			tend_q <= tile_end;
		end else if (cmd.mac) begin
			for (int r = 0; r < igt_pkg::TILE_ROWS; r++) begin
				a_sh_q[r] <= a_sh_q[r] >> a_shift;
			end
			for (int c = 0; c < igt_pkg::TILE_COLS; c++) begin
				b_sh_q[c] <= b_sh_q[c] >> igt_pkg::ELEM_W;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < igt_pkg::NUM_ACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			for (int i = 0; i < igt_pkg::NUM_ACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.mac) begin
			for (int i = 0; i < igt_pkg::NUM_ACC; i++) begin
				acc_q[i] <= acc_q[i] + igt_pkg::ACC_W'(prod[i]);
			end
		end
	end

	// map the emit index to stored position and accumulator
	always_comb begin
		if (transpose) begin
			e_row = igt_pkg::POS_W'(cmd.emit_idx / igt_pkg::TILE_ROWS);
			e_col = igt_pkg::POS_W'(cmd.emit_idx % igt_pkg::TILE_ROWS);
			e_acc = igt_pkg::ACC_IDX_W'((cmd.emit_idx % igt_pkg::TILE_ROWS) * igt_pkg::TILE_COLS
				+ cmd.emit_idx / igt_pkg::TILE_ROWS);
		end else begin
			e_row = igt_pkg::POS_W'(cmd.emit_idx / igt_pkg::TILE_COLS);
			e_col = igt_pkg::POS_W'(cmd.emit_idx % igt_pkg::TILE_COLS);
			e_acc = cmd.emit_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_row_q   <= e_row;
			out_col_q   <= e_col;
			out_value_q <= acc_q[e_acc];
			out_last_q  <= cmd.clr;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.out_row      = out_row_q;
	assign res.out_col      = out_col_q;
	assign res.value        = signed'(out_value_q);
	assign res.last_of_tile = out_last_q;

	assign sts.cnt      = cnt_q;
	assign sts.tend     = tend_q;
	assign sts.out_free = !out_valid_q || res.ready;

endmodule
